// ===== rtl/core/pccc_pkg.sv =====
// Shared types, constants and the palette table of the pixel colour class classifier.
// Has no dependencies. Every module in rtl/core imports it.
package pccc_pkg;

   localparam int CHANNELS   = 3;
   localparam int PIX_BITS   = 8;
   localparam int QUOT_BITS  = 8;
   localparam int NUM_BITS   = PIX_BITS + QUOT_BITS;
   localparam int CLASS_BITS = 4;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef enum logic [CLASS_BITS-1:0] {
      CLASS_BLACK  = 4'd0,
      CLASS_RED    = 4'd1,
      CLASS_ORANGE = 4'd2,
      CLASS_BROWN  = 4'd3,
      CLASS_YELLOW = 4'd4,
      CLASS_LIME   = 4'd5,
      CLASS_GREEN  = 4'd6,
      CLASS_CYAN   = 4'd7,
      CLASS_BLUE   = 4'd8
   } class_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
   } rgb_type;

   // Per channel: upper half is the partial remainder, lower half holds the
   // numerator bits still to be shifted in and the quotient bits already made.
   typedef struct packed {
      logic [CHANNELS-1:0][NUM_BITS-1:0] work;
      logic [PIX_BITS-1:0]               divisor;
   } div_data_type;

   function automatic rgb_type palette(input class_type cls);
      rgb_type col;
      unique case (cls)
         CLASS_BLACK:  col = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
         CLASS_RED:    col = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
         CLASS_ORANGE: col = '{red: 8'd255, green: 8'd128, blue: 8'd0};
         CLASS_BROWN:  col = '{red: 8'd128, green: 8'd128, blue: 8'd0};
         CLASS_YELLOW: col = '{red: 8'd255, green: 8'd255, blue: 8'd0};
         CLASS_LIME:   col = '{red: 8'd50,  green: 8'd255, blue: 8'd50};
         CLASS_GREEN:  col = '{red: 8'd0,   green: 8'd100, blue: 8'd0};
         CLASS_CYAN:   col = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
         CLASS_BLUE:   col = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
         default:      col = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
      endcase
      return col;
   endfunction

endpackage

// ===== rtl/core/pccc_prep.sv =====
// Front stage: channel minimum and maximum, and the numerators 255*(c-min).
// Depends on pccc_pkg.
module pccc_prep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [pccc_pkg::PIX_BITS-1:0]    in_red,
   input  logic [pccc_pkg::PIX_BITS-1:0]    in_green,
   input  logic [pccc_pkg::PIX_BITS-1:0]    in_blue,
   output logic                             out_valid,
   input  logic                             out_ready,
   output pccc_pkg::div_data_type           out_data
);
   import pccc_pkg::*;

   logic                               valid_ff;
   div_data_type                       data_ff;
   div_data_type                       data_in;
   logic [CHANNELS-1:0][PIX_BITS-1:0]  chan;
   logic [PIX_BITS-1:0]                mn;
   logic [PIX_BITS-1:0]                mx;

   assign chan[CH_RED]   = in_red;
   assign chan[CH_GREEN] = in_green;
   assign chan[CH_BLUE]  = in_blue;

   always_comb begin
      logic [PIX_BITS-1:0] diff;
      mn = chan[CH_RED];
      mx = chan[CH_RED];
      for (int ch = 1; ch < CHANNELS; ch++) begin
         if (chan[ch] < mn) mn = chan[ch];
         if (chan[ch] > mx) mx = chan[ch];
      end
      // A black pixel has all numerators zero; a divisor of one then yields zero.
      data_in.divisor = (mx == '0) ? PIX_BITS'(1) : mx;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         diff = chan[ch] - mn;
         data_in.work[ch] = {diff, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, diff};
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/core/pccc_div_cell.sv =====
// One cell of the divider chain: one restoring quotient bit for all three channels.
// Depends on pccc_pkg.
module pccc_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  pccc_pkg::div_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output pccc_pkg::div_data_type  out_data
);
   import pccc_pkg::*;

   logic         valid_ff;
   div_data_type data_ff;
   div_data_type data_in;

   always_comb begin
      logic [PIX_BITS:0] trial;
      logic              q_bit;
      data_in.divisor = in_data.divisor;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         trial = {in_data.work[ch][NUM_BITS-1 -: PIX_BITS], in_data.work[ch][QUOT_BITS-1]};
         q_bit = (trial >= {1'b0, in_data.divisor});
         if (q_bit) begin
            trial = trial - {1'b0, in_data.divisor};
         end
         data_in.work[ch] = {trial[PIX_BITS-1:0], in_data.work[ch][QUOT_BITS-2:0], q_bit};
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   // The partial remainder must always stay below the divisor.
   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_rem_chk
      a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
         valid_ff |-> (data_ff.work[ch][NUM_BITS-1 -: PIX_BITS] < data_ff.divisor))
         else $error("partial remainder not below divisor");
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.divisor != '0))
      else $error("zero divisor in divider chain");

endmodule

// ===== rtl/core/pccc_classify.sv =====
// Output stage: colour class tests on the normalised triple and palette lookup.
// Depends on pccc_pkg.
module pccc_classify (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  pccc_pkg::div_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output pccc_pkg::rgb_type       out_norm,
   output pccc_pkg::class_type     out_class,
   output pccc_pkg::rgb_type       out_palette
);
   import pccc_pkg::*;

   logic      valid_ff;
   rgb_type   norm_ff;
   rgb_type   norm_in;
   class_type class_ff;
   class_type class_in;
   rgb_type   palette_ff;

   // Products need at most twelve bits (ten times 255).
   logic [11:0] r;
   logic [11:0] g;
   logic [11:0] b;

   assign norm_in.red   = in_data.work[CH_RED][QUOT_BITS-1:0];
   assign norm_in.green = in_data.work[CH_GREEN][QUOT_BITS-1:0];
   assign norm_in.blue  = in_data.work[CH_BLUE][QUOT_BITS-1:0];

   assign r = {4'b0, norm_in.red};
   assign g = {4'b0, norm_in.green};
   assign b = {4'b0, norm_in.blue};

   always_comb begin
      if ((12'd5 * r < 12'd3 * g) && (g > 12'd40) && (12'd5 * b < 12'd6 * g)) begin
         class_in = (r > b) ? CLASS_LIME : CLASS_GREEN;
      end else if ((r > 12'd50) && (12'd10 * b < r)) begin
         if ((r < 12'd100) || (12'd5 * g < r)) begin
            if (12'd2 * g < r) begin
               class_in = CLASS_RED;
            end else if (12'd10 * g < 12'd9 * r) begin
               class_in = CLASS_BROWN;
            end else begin
               class_in = CLASS_YELLOW;
            end
         end else begin
            class_in = (12'd2 * g < r) ? CLASS_ORANGE : CLASS_YELLOW;
         end
      end else if ((r < 12'd10) && (g < 12'd45) && (b > 12'd80)) begin
         class_in = CLASS_BLUE;
      end else if ((r < 12'd20) && (g > 12'd30) && (b > 12'd70)) begin
         class_in = CLASS_CYAN;
      end else begin
         class_in = CLASS_BLACK;
      end
   end

   assign in_ready    = !valid_ff || out_ready;
   assign out_valid   = valid_ff;
   assign out_norm    = norm_ff;
   assign out_class   = class_ff;
   assign out_palette = palette_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         norm_ff    <= norm_in;
         class_ff   <= class_in;
         palette_ff <= palette(class_in);
      end
   end

   a_zero_is_black: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && norm_ff == '0) |-> (class_ff == CLASS_BLACK))
      else $error("all-zero colour not classed black");

   a_lime_red_over_blue: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && class_ff == CLASS_LIME) |-> (norm_ff.red > norm_ff.blue))
      else $error("lime class without red above blue");

endmodule

// ===== rtl/core/pixel_color_class_classifier.sv =====
// Pixel colour class classifier, top level: front stage, divider chain, output stage.
// Depends on pccc_pkg, pccc_prep, pccc_div_cell and pccc_classify.
//
// Usage. Each beat on the req_ channel carries one RGB pixel. Each beat on the
// rsp_ channel carries, in the same order, the saturation-stretched colour
// floor(255*(c-min)/max) per channel, the colour class number and the fixed
// palette colour of that class. A black pixel gives a zero colour and class
// black. Both channels use valid and ready.
//
// From an accepted request beat to the response beat, the front stage registers
// the minimum, maximum and numerators, a chain of divider cells (each cell settles
// one quotient bit of all three channels and hands its work on to the next) follows,
// and the output stage registers the class tests and palette lookup. Throughput is
// one pixel per cycle while the receiver takes every response beat.
//
// Every stage holds one beat and takes a new one whenever it is empty or its
// successor takes its beat, so a stalled receiver fills the chain's bubbles
// first; req_ready falls only when all ten stages are occupied. A synchronous
// reset empties every stage; no result is pending after reset.
module pixel_color_class_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pccc_pkg::PIX_BITS-1:0]       req_in_red,
   input  logic [pccc_pkg::PIX_BITS-1:0]       req_in_green,
   input  logic [pccc_pkg::PIX_BITS-1:0]       req_in_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pccc_pkg::PIX_BITS-1:0]       rsp_norm_red,
   output logic [pccc_pkg::PIX_BITS-1:0]       rsp_norm_green,
   output logic [pccc_pkg::PIX_BITS-1:0]       rsp_norm_blue,
   output logic [pccc_pkg::CLASS_BITS-1:0]     rsp_class_id,
   output logic [pccc_pkg::PIX_BITS-1:0]       rsp_palette_red,
   output logic [pccc_pkg::PIX_BITS-1:0]       rsp_palette_green,
   output logic [pccc_pkg::PIX_BITS-1:0]       rsp_palette_blue
);
   import pccc_pkg::*;

   // Link k feeds divider cell k; link QUOT_BITS feeds the output stage.
   logic         link_valid [QUOT_BITS+1];
   logic         link_ready [QUOT_BITS+1];
   div_data_type link_data  [QUOT_BITS+1];

   rgb_type      norm;
   class_type    cls;
   rgb_type      pal;

   pccc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_in_red),
      .in_green  (req_in_green),
      .in_blue   (req_in_blue),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_cell
      pccc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   pccc_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (link_valid[QUOT_BITS]),
      .in_ready    (link_ready[QUOT_BITS]),
      .in_data     (link_data[QUOT_BITS]),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_norm    (norm),
      .out_class   (cls),
      .out_palette (pal)
   );

   assign rsp_norm_red      = norm.red;
   assign rsp_norm_green    = norm.green;
   assign rsp_norm_blue     = norm.blue;
   assign rsp_class_id      = cls;
   assign rsp_palette_red   = pal.red;
   assign rsp_palette_green = pal.green;
   assign rsp_palette_blue  = pal.blue;

   // A receiver that takes beats lets every stage advance, so the input is open.
   a_open_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side blocked while response side is ready");

endmodule

// ===== bench/pixel_color_class_classifier_tb.sv =====
// Self-checking testbench for the pixel colour class classifier: directed and random pixels.
// Depends on pccc_pkg and the pixel_color_class_classifier top level; needs nothing else.
module pixel_color_class_classifier_tb;

   import pccc_pkg::*;

   // The block is ten stages deep; the drain wait is long enough to show any beat still in flight.
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 900;
   localparam int PHASES       = 4;

   // One expected response beat: stretched colour, class and palette colour.
   typedef struct packed {
      rgb_type   norm;
      class_type cls;
      rgb_type   shade;
   } colour_result_type;

   // One pixel waiting to be offered, tagged with the idling phase it belongs to.
   typedef struct {
      rgb_type pixel;
      int      phase;
   } pending_pixel_type;

   // Idling per phase: none, sender idle, receiver stalling, then both at once.
   int send_idle_pct  [PHASES] = '{0, 66, 0, 19};
   int recv_stall_pct [PHASES] = '{0, 0, 66, 19};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic [PIX_BITS-1:0]   req_in_red   = '0;
   logic [PIX_BITS-1:0]   req_in_green = '0;
   logic [PIX_BITS-1:0]   req_in_blue  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   logic [PIX_BITS-1:0]   rsp_norm_red;
   logic [PIX_BITS-1:0]   rsp_norm_green;
   logic [PIX_BITS-1:0]   rsp_norm_blue;
   logic [CLASS_BITS-1:0] rsp_class_id;
   logic [PIX_BITS-1:0]   rsp_palette_red;
   logic [PIX_BITS-1:0]   rsp_palette_green;
   logic [PIX_BITS-1:0]   rsp_palette_blue;

   pending_pixel_type pending_pixels [$];
   colour_result_type expected_colours [$];

   int cur_phase      = 0;
   int accepted_count = 0;
   int total_pixels   = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   pixel_color_class_classifier DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_red        (req_in_red),
      .req_in_green      (req_in_green),
      .req_in_blue       (req_in_blue),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_norm_red      (rsp_norm_red),
      .rsp_norm_green    (rsp_norm_green),
      .rsp_norm_blue     (rsp_norm_blue),
      .rsp_class_id      (rsp_class_id),
      .rsp_palette_red   (rsp_palette_red),
      .rsp_palette_green (rsp_palette_green),
      .rsp_palette_blue  (rsp_palette_blue)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the response to one pixel. The channel at the minimum always
   // stretches to zero, and a pixel whose maximum is zero stays all zeros.
   function automatic colour_result_type predict_colour(input rgb_type px);
      int                lo;
      int                hi;
      int                r;
      int                g;
      int                b;
      colour_result_type res;
      lo = px.red;
      hi = px.red;
      if (px.green < lo) lo = px.green;
      if (px.blue < lo) lo = px.blue;
      if (px.green > hi) hi = px.green;
      if (px.blue > hi) hi = px.blue;
      if (hi == 0) begin
         r = 0;
         g = 0;
         b = 0;
      end else begin
         r = (255 * (px.red - lo)) / hi;
         g = (255 * (px.green - lo)) / hi;
         b = (255 * (px.blue - lo)) / hi;
      end
      res.norm = '{red: r[7:0], green: g[7:0], blue: b[7:0]};

      // The tests are tried in a fixed order; the first family that fits wins.
      if (5 * r < 3 * g && g > 40 && 5 * b < 6 * g) begin
         res.cls = (r > b) ? CLASS_LIME : CLASS_GREEN;
      end else if (r > 50 && 10 * b < r) begin
         if (r < 100 || 5 * g < r) begin
            if (2 * g < r) res.cls = CLASS_RED;
            else if (10 * g < 9 * r) res.cls = CLASS_BROWN;
            else res.cls = CLASS_YELLOW;
         end else begin
            res.cls = (2 * g < r) ? CLASS_ORANGE : CLASS_YELLOW;
         end
      end else if (r < 10 && g < 45 && b > 80) begin
         res.cls = CLASS_BLUE;
      end else if (r < 20 && g > 30 && b > 70) begin
         res.cls = CLASS_CYAN;
      end else begin
         res.cls = CLASS_BLACK;
      end

      case (res.cls)
         CLASS_RED:    res.shade = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
         CLASS_ORANGE: res.shade = '{red: 8'd255, green: 8'd128, blue: 8'd0};
         CLASS_BROWN:  res.shade = '{red: 8'd128, green: 8'd128, blue: 8'd0};
         CLASS_YELLOW: res.shade = '{red: 8'd255, green: 8'd255, blue: 8'd0};
         CLASS_LIME:   res.shade = '{red: 8'd50,  green: 8'd255, blue: 8'd50};
         CLASS_GREEN:  res.shade = '{red: 8'd0,   green: 8'd100, blue: 8'd0};
         CLASS_CYAN:   res.shade = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
         CLASS_BLUE:   res.shade = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
         default:      res.shade = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   task automatic queue_pixel(input int red, input int green, input int blue, input int phase);
      pending_pixel_type item;
      item.pixel = '{red: red[7:0], green: green[7:0], blue: blue[7:0]};
      item.phase = phase;
      pending_pixels.insert(pending_pixels.size(), item);
   endtask

   // Request driver. A beat stays on the port until it is accepted; a fresh one is
   // offered only when the port is free, either idle or just accepted. Every
   // accepted beat has its expected response worked out on the spot.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_colours.insert(expected_colours.size(),
                                    predict_colour('{red: req_in_red,
                                                     green: req_in_green,
                                                     blue: req_in_blue}));
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct[pending_pixels[0].phase]) begin
               req_in_red   <= pending_pixels[0].pixel.red;
               req_in_green <= pending_pixels[0].pixel.green;
               req_in_blue  <= pending_pixels[0].pixel.blue;
               cur_phase    <= pending_pixels[0].phase;
               req_valid    <= 1'b1;
               pending_pixels.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Each accepted response beat is checked field by field
   // against the oldest expectation; the receiver stalls at random by phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colours.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual class %0d",
                        $time, rsp_class_id);
               error_count++;
            end else begin
               check_field("norm_red",      expected_colours[0].norm.red,    rsp_norm_red);
               check_field("norm_green",    expected_colours[0].norm.green,  rsp_norm_green);
               check_field("norm_blue",     expected_colours[0].norm.blue,   rsp_norm_blue);
               check_field("class_id",      8'(expected_colours[0].cls),     8'(rsp_class_id));
               check_field("palette_red",   expected_colours[0].shade.red,   rsp_palette_red);
               check_field("palette_green", expected_colours[0].shade.green, rsp_palette_green);
               check_field("palette_blue",  expected_colours[0].shade.blue,  rsp_palette_blue);
               expected_colours.delete(0);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct[cur_phase]);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int chan [3];
      int mode;
      int base;
      int top;

      // Directed pixels: black, grey and white, the channel extremes, and at
      // least one pixel that lands in each of the nine classes.
      queue_pixel(0,   0,   0,   0);
      queue_pixel(128, 128, 128, 0);
      queue_pixel(255, 255, 255, 0);
      queue_pixel(255, 0,   0,   0);
      queue_pixel(255, 80,  0,   0);
      queue_pixel(200, 166, 128, 0);
      queue_pixel(255, 255, 0,   0);
      queue_pixel(100, 255, 0,   0);
      queue_pixel(0,   255, 0,   0);
      queue_pixel(0,   100, 255, 0);
      queue_pixel(0,   0,   255, 0);
      queue_pixel(0,   255, 255, 0);
      queue_pixel(255, 0,   255, 0);
      queue_pixel(1,   0,   0,   0);
      queue_pixel(0,   0,   1,   0);
      queue_pixel(1,   1,   1,   0);
      queue_pixel(255, 254, 253, 0);
      queue_pixel(254, 255, 0,   0);
      queue_pixel(170, 85,  0,   0);
      queue_pixel(60,  0,   0,   0);
      queue_pixel(200, 164, 128, 0);

      // Random pixels in four phases of idling. The draws mix uniform pixels with
      // saturated ones, near-grey ones and pixels with one dominant channel, so
      // that the ratio tests are crossed from both sides.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         mode = $urandom_range(0, 3);
         case (mode)
            0: begin
               for (int c = 0; c < 3; c++) chan[c] = $urandom_range(0, 255);
            end
            1: begin
               for (int c = 0; c < 3; c++) begin
                  case ($urandom_range(0, 2))
                     0:       chan[c] = 0;
                     1:       chan[c] = 255;
                     default: chan[c] = $urandom_range(0, 255);
                  endcase
               end
            end
            2: begin
               base = $urandom_range(0, 255);
               for (int c = 0; c < 3; c++) begin
                  chan[c] = base + $urandom_range(0, 40) - 20;
                  if (chan[c] < 0) chan[c] = 0;
                  if (chan[c] > 255) chan[c] = 255;
               end
            end
            default: begin
               top = $urandom_range(150, 255);
               for (int c = 0; c < 3; c++) chan[c] = $urandom_range(0, top);
               chan[$urandom_range(0, 2)] = top;
            end
         endcase
         queue_pixel(chan[0], chan[1], chan[2], (i * PHASES) / RANDOM_BEATS);
      end
      total_pixels = pending_pixels.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to be accepted and every response to be seen, then
      // give the pipeline time to show any stray beat.
      while (accepted_count != total_pixels || expected_colours.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_colours.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== pixel_color_class_classifier.f =====
rtl/core/pccc_pkg.sv
rtl/core/pccc_prep.sv
rtl/core/pccc_div_cell.sv
rtl/core/pccc_classify.sv
rtl/core/pixel_color_class_classifier.sv
bench/pixel_color_class_classifier_tb.sv
